@@ rtl/q15_linear_gain_ramp_defines.svh @@
// Assertion macros shared by the q15_linear_gain_ramp RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef Q15_LINEAR_GAIN_RAMP_DEFINES_SVH
`define Q15_LINEAR_GAIN_RAMP_DEFINES_SVH

// Check a property on every rising edge outside reset.
`define Q15LGR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define Q15LGR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/q15lgr_pkg.sv @@
// Shared widths, reset values, register indexes and types of the Q15 gain ramp.
// No dependencies.
`timescale 1ns / 1ps

package q15lgr_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int GAIN_W     = 16;
  localparam int SHIFT_W    = 5;
  localparam int BLEN_W     = 13;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int ACC_W      = 32;
  localparam int FRAC_BITS  = 15;
  localparam int DIVD_W     = 31;
  localparam int DIV_STEPS  = DIVD_W;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

  localparam int MAX_BLOCK_DEF = 4096;

  localparam logic [GAIN_W-1:0]  GAIN_START_RST = 16'h7FFF;
  localparam logic [GAIN_W-1:0]  GAIN_END_RST   = 16'h7FFF;
  localparam logic [SHIFT_W-1:0] POST_SHIFT_RST = 5'd0;
  localparam logic [BLEN_W-1:0]  BLOCK_LEN_RST  = 13'd1024;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_GAIN_START = 2'd0,
    REG_GAIN_END   = 2'd1,
    REG_POST_SHIFT = 2'd2,
    REG_BLOCK_LEN  = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

@@ rtl/q15lgr_div.sv @@
// Restoring divider, one quotient bit per cycle, for the per-block ramp step.
// Depends on q15lgr_pkg and q15_linear_gain_ramp_defines.svh.
`timescale 1ns / 1ps
`include "q15_linear_gain_ramp_defines.svh"

module q15lgr_div #(
  parameter int DVS_W = 12
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [q15lgr_pkg::DIVD_W-1:0] dividend,
  input  logic [DVS_W-1:0]             divisor,
  output logic [q15lgr_pkg::DIVD_W-1:0] quotient,
  output q15lgr_pkg::div_stat_t        stat
);
  import q15lgr_pkg::*;

  logic                 busy_r;
  logic                 done_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic [DVS_W-1:0]     rem_r;
  logic [DVS_W-1:0]     dvs_r;
  logic [DIVD_W-1:0]    quo_r;

  logic [DVS_W:0]       trial;
  logic                 ge;
  logic [DVS_W:0]       diff;
  logic [DVS_W-1:0]     rem_nxt;
  logic [DIVD_W-1:0]    quo_nxt;

  always_comb begin
    trial   = {rem_r, quo_r[DIVD_W-1]};
    ge      = (trial >= {1'b0, dvs_r});
    diff    = trial - {1'b0, dvs_r};
    rem_nxt = ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
    quo_nxt = {quo_r[DIVD_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

  `Q15LGR_ASSERT(a_start_idle, start |-> !busy_r, "divider started while busy")
  `Q15LGR_ASSERT(a_done_after_busy, done_r |-> $past(busy_r), "done without a running division")
  `Q15LGR_ASSERT_ALWAYS(a_rst_quiet, !rst_n |=> (!busy_r && !done_r), "divider active after reset")

endmodule

@@ rtl/q15_linear_gain_ramp.sv @@
// Q15 linear gain ramp: top level with sequencer, multiplier and output register.
// Depends on q15lgr_pkg, q15lgr_div and q15_linear_gain_ramp_defines.svh.
//
// Each sample is multiplied by a Q15 gain that ramps from gain_start toward
// gain_end over block_length samples, shifted right by 15 - post_shift (floor)
// and saturated to 16 bits; out_tlast marks the last sample of each block. A
// sample is multiplied on accept; the registered product is then shifted and
// saturated into the output register. For the first sample of every block the
// ramp step is found by a bit-serial divider before the sample completes. The
// input stalls while a sample is in flight; a finished sample waits in the
// output register and does not block acceptance of the next one. gain_start,
// gain_end and block_length take effect at the next block start; post_shift
// takes effect at once. Write registers only while the block is idle.
`timescale 1ns / 1ps
`include "q15_linear_gain_ramp_defines.svh"

module q15_linear_gain_ramp #(
  parameter int MAX_BLOCK = q15lgr_pkg::MAX_BLOCK_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [q15lgr_pkg::SAMPLE_W-1:0]     in_tdata,   // [15:0] sample_in
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [q15lgr_pkg::SAMPLE_W-1:0]     out_tdata,  // [15:0] sample_out
  output logic                                out_tlast,
  input  logic                                cfg_wr_en,
  input  logic [q15lgr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [q15lgr_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import q15lgr_pkg::*;

  localparam int LEN_W = $clog2(MAX_BLOCK + 1);
  localparam int DVS_W = LEN_W - 1;
  localparam int CMP_W = (LEN_W > BLEN_W) ? LEN_W : BLEN_W;
  localparam int LEN_RST = (MAX_BLOCK < 1024) ? MAX_BLOCK : 1024;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIV,
    S_RES
  } state_t;

  typedef enum logic [1:0] {
    DIR_HOLD,
    DIR_UP,
    DIR_DOWN
  } dir_t;

  state_t                    state_r;
  logic signed [GAIN_W-1:0]  cfg_gain_start_r;
  logic signed [GAIN_W-1:0]  cfg_gain_end_r;
  logic [SHIFT_W-1:0]        cfg_post_shift_r;
  logic [BLEN_W-1:0]         cfg_block_len_r;

  logic signed [GAIN_W-1:0]  blk_start_r;
  dir_t                      blk_dir_r;
  logic [LEN_W-1:0]          blk_len_r;
  logic [LEN_W-1:0]          pos_r;
  logic                      phase_r;
  logic [ACC_W-1:0]          accum_r;
  logic [ACC_W-1:0]          step_r;
  logic signed [GAIN_W-1:0]  gain_r;
  logic signed [ACC_W-1:0]   prod_r;

  logic                      out_tvalid_r;
  logic [SAMPLE_W-1:0]       out_tdata_r;
  logic                      out_tlast_r;

  logic                      accept;
  logic                      blk_first;
  logic signed [SAMPLE_W-1:0] in_sample;
  logic signed [GAIN_W-1:0]  gain_mul;
  logic signed [ACC_W-1:0]   prod_nxt;
  logic [CMP_W-1:0]          len_raw;
  logic [CMP_W-1:0]          len_clamp;
  logic [LEN_W-1:0]          len_nxt;
  logic [GAIN_W:0]           diff_full;
  logic [FRAC_BITS-1:0]      diff_sat;
  dir_t                      dir_nxt;
  logic [DIVD_W-1:0]         div_dividend;
  logic [DIVD_W-1:0]         div_quotient;
  div_stat_t                 div_stat;

  logic [SHIFT_W:0]          shift_k;
  logic signed [ACC_W-1:0]   shifted;
  logic [SAMPLE_W-1:0]       sat_nxt;
  logic [ACC_W-1:0]          accum_nxt;
  logic [GAIN_W-1:0]         gain_off;
  logic signed [GAIN_W-1:0]  gain_nxt;
  logic [LEN_W-1:0]          pos_inc;
  logic                      last_nxt;
  logic                      out_load;

  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign blk_first = (pos_r == '0);
  assign in_sample = in_tdata;

  always_comb begin
    gain_mul = blk_first ? cfg_gain_start_r : gain_r;
    prod_nxt = in_sample * gain_mul;

    len_raw = CMP_W'(cfg_block_len_r);
    if (len_raw < CMP_W'(2)) begin
      len_clamp = CMP_W'(2);
    end else if (len_raw > CMP_W'(MAX_BLOCK)) begin
      len_clamp = CMP_W'(MAX_BLOCK);
    end else begin
      len_clamp = len_raw;
    end
    len_nxt = LEN_W'(len_clamp);

    if (cfg_gain_end_r > cfg_gain_start_r) begin
      dir_nxt   = DIR_UP;
      diff_full = (GAIN_W+1)'(cfg_gain_end_r) - (GAIN_W+1)'(cfg_gain_start_r);
    end else if (cfg_gain_end_r < cfg_gain_start_r) begin
      dir_nxt   = DIR_DOWN;
      diff_full = (GAIN_W+1)'(cfg_gain_start_r) - (GAIN_W+1)'(cfg_gain_end_r);
    end else begin
      dir_nxt   = DIR_HOLD;
      diff_full = '0;
    end
    diff_sat     = (diff_full > (GAIN_W+1)'(32767)) ? '1 : diff_full[FRAC_BITS-1:0];
    div_dividend = {diff_sat, 16'd0};
  end

  always_comb begin
    shift_k = (SHIFT_W+1)'(FRAC_BITS) - {cfg_post_shift_r[SHIFT_W-1], cfg_post_shift_r};
    shifted = prod_r >>> shift_k[SHIFT_W-1:0];
    if (shifted > 32'sd32767) begin
      sat_nxt = 16'h7FFF;
    end else if (shifted < -32'sd32768) begin
      sat_nxt = 16'h8000;
    end else begin
      sat_nxt = shifted[SAMPLE_W-1:0];
    end

    accum_nxt = accum_r + step_r;
    gain_off  = accum_nxt[ACC_W-1:ACC_W-GAIN_W];
    case (blk_dir_r)
      DIR_UP:   gain_nxt = blk_start_r + signed'(gain_off);
      DIR_DOWN: gain_nxt = blk_start_r - signed'(gain_off);
      default:  gain_nxt = blk_start_r;
    endcase

    pos_inc  = pos_r + 1'b1;
    last_nxt = (pos_inc >= blk_len_r);
    out_load = (state_r == S_RES) && (!out_tvalid_r || out_tready);
  end

  q15lgr_div #(
    .DVS_W(DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && blk_first),
    .dividend (div_dividend),
    .divisor  (len_nxt[LEN_W-1:1]),
    .quotient (div_quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= S_IDLE;
      cfg_gain_start_r <= GAIN_START_RST;
      cfg_gain_end_r   <= GAIN_END_RST;
      cfg_post_shift_r <= POST_SHIFT_RST;
      cfg_block_len_r  <= BLOCK_LEN_RST;
      blk_start_r      <= GAIN_START_RST;
      blk_dir_r        <= DIR_HOLD;
      blk_len_r        <= LEN_W'(LEN_RST);
      pos_r            <= '0;
      phase_r          <= 1'b0;
      accum_r          <= '0;
      step_r           <= '0;
      gain_r           <= GAIN_START_RST;
      out_tvalid_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_reg_t'(cfg_addr))
          REG_GAIN_START: cfg_gain_start_r <= cfg_wdata;
          REG_GAIN_END:   cfg_gain_end_r   <= cfg_wdata;
          REG_POST_SHIFT: cfg_post_shift_r <= cfg_wdata[SHIFT_W-1:0];
          REG_BLOCK_LEN:  cfg_block_len_r  <= cfg_wdata[BLEN_W-1:0];
          default: ;
        endcase
      end

      if (out_tvalid_r && out_tready && !out_load) begin
        out_tvalid_r <= 1'b0;
      end

      case (state_r)
        S_IDLE: begin
          if (accept) begin
            prod_r <= prod_nxt;
            if (blk_first) begin
              blk_start_r <= cfg_gain_start_r;
              blk_dir_r   <= dir_nxt;
              blk_len_r   <= len_nxt;
              gain_r      <= cfg_gain_start_r;
              accum_r     <= '0;
              phase_r     <= 1'b0;
              state_r     <= S_DIV;
            end else begin
              state_r <= S_RES;
            end
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            step_r  <= {1'b0, div_quotient};
            state_r <= S_RES;
          end
        end
        S_RES: begin
          if (out_load) begin
            out_tvalid_r <= 1'b1;
            out_tdata_r  <= sat_nxt;
            out_tlast_r  <= last_nxt;
            if (phase_r) begin
              accum_r <= accum_nxt;
              gain_r  <= gain_nxt;
            end
            phase_r <= last_nxt ? 1'b0 : !phase_r;
            pos_r   <= last_nxt ? '0 : pos_inc;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;

  `Q15LGR_ASSERT(a_one_in_flight, accept |=> !in_tready, "second sample taken while busy")
  `Q15LGR_ASSERT(a_pos_range, pos_r < blk_len_r, "sample position beyond block length")
  `Q15LGR_ASSERT(a_last_wraps, (out_tvalid && out_tlast) |-> (pos_r == '0), "block end did not wrap")
  `Q15LGR_ASSERT(a_div_in_seq, div_stat.done |-> (state_r == S_DIV), "step ready outside division")

endmodule
